[design/pbrd_pkg.sv]
package pbrd_pkg;

  localparam int WARMUP_SAMPLES_DEF = 10;

  localparam int CFG_W   = 16;
  localparam int ADDR_W  = 5;
  localparam int PDATA_W = 32;

  // divider: 28-bit dividend covers both sum*256 and the rate numerator
  localparam int DIV_W = 28;
  localparam int DVS_W = 16;

  localparam logic [23:0] RATE_NUM     = 24'd15360000;
  localparam logic [23:0] FALLBACK_THR = 24'd2048000;

  localparam logic [2:0] REG_ARM_LEVEL = 3'd0;
  localparam logic [2:0] REG_MIN_INT   = 3'd1;
  localparam logic [2:0] REG_MAX_INT   = 3'd2;
  localparam logic [2:0] REG_TIMEOUT   = 3'd3;
  localparam logic [2:0] REG_THR_GAIN  = 3'd4;
  localparam logic [2:0] REG_RATE_GAIN = 3'd5;

  localparam logic [CFG_W-1:0] ARM_LEVEL_RST = 16'd1000;
  localparam logic [CFG_W-1:0] MIN_INT_RST   = 16'd300;
  localparam logic [CFG_W-1:0] MAX_INT_RST   = 16'd2000;
  localparam logic [CFG_W-1:0] TIMEOUT_RST   = 16'd5000;
  localparam logic [CFG_W-1:0] THR_GAIN_RST  = 16'd1638;
  localparam logic [CFG_W-1:0] RATE_GAIN_RST = 16'd19661;

  typedef struct packed {
    logic [CFG_W-1:0] arm_level;
    logic [CFG_W-1:0] min_interval_ms;
    logic [CFG_W-1:0] max_interval_ms;
    logic [CFG_W-1:0] timeout_ms;
    logic [CFG_W-1:0] threshold_gain;
    logic [CFG_W-1:0] rate_gain;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic warm_acc;
    logic arm_fallback;
    logic div_warm;
    logic arm_div;
    logic mul_thr;
    logic fold_thr;
    logic edge_eval;
    logic div_rate;
    logic rate_sat;
    logic mul_rate;
    logic rate_set;
    logic fold_rate;
    logic tmo_eval;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic armed;
    logic x_ge_arm;
    logic warm_done;
    logic sum_zero;
    logic rise;
    logic in_win;
    logic rate_zero;
    logic div_done;
  } sts_t;

endpackage

[design/pbrd_regs.sv]
module pbrd_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pbrd_pkg::ADDR_W-1:0]   paddr,
  input  logic [pbrd_pkg::PDATA_W-1:0]  pwdata,
  output logic [pbrd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output pbrd_pkg::cfg_t                cfg
);
  import pbrd_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.arm_level       <= ARM_LEVEL_RST;
      cfg.min_interval_ms <= MIN_INT_RST;
      cfg.max_interval_ms <= MAX_INT_RST;
      cfg.timeout_ms      <= TIMEOUT_RST;
      cfg.threshold_gain  <= THR_GAIN_RST;
      cfg.rate_gain       <= RATE_GAIN_RST;
    end else if (wr) begin
      unique case (idx)
        REG_ARM_LEVEL: cfg.arm_level       <= pwdata[CFG_W-1:0];
        REG_MIN_INT:   cfg.min_interval_ms <= pwdata[CFG_W-1:0];
        REG_MAX_INT:   cfg.max_interval_ms <= pwdata[CFG_W-1:0];
        REG_TIMEOUT:   cfg.timeout_ms      <= pwdata[CFG_W-1:0];
        REG_THR_GAIN:  cfg.threshold_gain  <= pwdata[CFG_W-1:0];
        REG_RATE_GAIN: cfg.rate_gain       <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ARM_LEVEL: prdata = {16'h0000, cfg.arm_level};
      REG_MIN_INT:   prdata = {16'h0000, cfg.min_interval_ms};
      REG_MAX_INT:   prdata = {16'h0000, cfg.max_interval_ms};
      REG_TIMEOUT:   prdata = {16'h0000, cfg.timeout_ms};
      REG_THR_GAIN:  prdata = {16'h0000, cfg.threshold_gain};
      REG_RATE_GAIN: prdata = {16'h0000, cfg.rate_gain};
      default:       prdata = '0;
    endcase
  end

endmodule

[design/pbrd_div.sv]
module pbrd_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [pbrd_pkg::DIV_W-1:0]   dividend,
  input  logic [pbrd_pkg::DVS_W-1:0]   divisor,
  output logic                         done,
  output logic [pbrd_pkg::DIV_W-1:0]   quotient
);
  import pbrd_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   shifted;
  logic             fits;

  // restoring division, one quotient bit per cycle, MSB first
  assign shifted = {rem, quotient[DIV_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      quotient <= {quotient[DIV_W-2:0], fits};
      rem      <= fits ? DVS_W'(shifted - {1'b0, dvs}) : shifted[DVS_W-1:0];
    end
  end

endmodule

[design/pbrd_dp.sv]
module pbrd_dp #(
  parameter int WARMUP_SAMPLES = pbrd_pkg::WARMUP_SAMPLES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  pbrd_pkg::cfg_t  cfg,
  input  pbrd_pkg::cmd_t  cmd,
  output pbrd_pkg::sts_t  sts,
  input  logic [15:0]     ir_sample,
  input  logic [31:0]     time_ms,
  input  logic            restart,
  output logic [15:0]     beat_rate,
  output logic            rate_updated,
  output logic            beat_edge,
  output logic            armed,
  output logic            timed_out
);
  import pbrd_pkg::*;

  localparam logic [3:0]       WARM_N   = 4'(WARMUP_SAMPLES);
  localparam logic [DVS_W-1:0] WARM_DVS = DVS_W'(WARMUP_SAMPLES);

  logic [15:0] x_r;
  logic [31:0] now_r;
  logic        is_armed;
  logic [3:0]  warm_cnt;
  logic [19:0] warm_sum;
  logic [23:0] thresh;
  logic        above;
  logic [31:0] last_beat;
  logic [15:0] rate;
  logic [15:0] rate_inst;
  logic        upd, edg, tmo;

  logic [23:0] xs;
  logic [31:0] d;
  logic        fall, ge_max, tmo_hit;

  logic               div_start;
  logic [DIV_W-1:0]   div_dvd;
  logic [DVS_W-1:0]   div_dvs;
  logic               div_done;
  logic [DIV_W-1:0]   quot;
  logic [23:0]        rate_num;
  logic [15:0]        rate_clip;

  logic [15:0]        mul_gain;
  logic signed [24:0] diff_t, diff_r, mul_diff;
  logic signed [41:0] prod;
  logic signed [41:0] rnd;
  logic signed [41:0] step;
  logic [25:0]        thr_sum;
  logic [17:0]        rate_sum;

  assign xs      = {x_r, 8'h00};
  assign d       = now_r - last_beat;
  assign fall    = (xs < thresh) && above;
  assign ge_max  = d >= {16'h0000, cfg.max_interval_ms};
  assign tmo_hit = (d > {16'h0000, cfg.timeout_ms}) && (rate != 16'h0000);

  assign sts.armed     = is_armed;
  assign sts.x_ge_arm  = x_r >= cfg.arm_level;
  assign sts.warm_done = warm_cnt >= WARM_N;
  assign sts.sum_zero  = warm_sum == 20'h00000;
  assign sts.rise      = (xs > thresh) && !above;
  assign sts.in_win    = (d > {16'h0000, cfg.min_interval_ms}) && !ge_max;
  assign sts.rate_zero = rate == 16'h0000;
  assign sts.div_done  = div_done;

  // in the window the spacing is below 2^16, so its low half is the divisor
  assign rate_num  = RATE_NUM + 24'(d[15:1]);
  assign div_start = cmd.div_warm | cmd.div_rate;
  assign div_dvd   = cmd.div_rate ? {4'h0, rate_num} : {warm_sum, 8'h00};
  assign div_dvs   = cmd.div_rate ? d[15:0] : WARM_DVS;
  assign rate_clip = (|quot[DIV_W-1:16]) ? 16'hFFFF : quot[15:0];

  pbrd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (quot)
  );

  // blend as old + g*(new - old) / 2^16, rounded; floor via arithmetic shift
  assign diff_t   = $signed({1'b0, xs}) - $signed({1'b0, thresh});
  assign diff_r   = $signed({9'h000, rate_inst}) - $signed({9'h000, rate});
  assign mul_gain = cmd.mul_rate ? cfg.rate_gain : cfg.threshold_gain;
  assign mul_diff = cmd.mul_rate ? diff_r : diff_t;
  assign rnd      = prod + 42'sd32768;
  assign step     = rnd >>> 16;
  assign thr_sum  = {2'b00, thresh} + step[25:0];
  assign rate_sum = {2'b00, rate} + step[17:0];

  always_ff @(posedge clk) begin
    if (cmd.mul_thr || cmd.mul_rate) begin
      prod <= $signed({1'b0, mul_gain}) * mul_diff;
    end
    if (cmd.load) begin
      x_r   <= ir_sample;
      now_r <= time_ms;
    end
    if (cmd.rate_sat) begin
      rate_inst <= rate_clip;
    end
    if (cmd.load_out) begin
      beat_rate    <= rate;
      rate_updated <= upd;
      beat_edge    <= edg;
      armed        <= is_armed;
      timed_out    <= tmo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_armed  <= 1'b0;
      warm_cnt  <= '0;
      warm_sum  <= '0;
      thresh    <= '0;
      above     <= 1'b0;
      last_beat <= '0;
      rate      <= '0;
      upd       <= 1'b0;
      edg       <= 1'b0;
      tmo       <= 1'b0;
    end else begin
      if (cmd.load) begin
        upd <= 1'b0;
        edg <= 1'b0;
        tmo <= 1'b0;
        if (restart) begin
          rate     <= '0;
          is_armed <= 1'b0;
          warm_cnt <= '0;
          warm_sum <= '0;
          above    <= 1'b0;
        end
      end
      if (cmd.warm_acc) begin
        warm_sum <= warm_sum + 20'(x_r);
        warm_cnt <= warm_cnt + 4'd1;
      end
      if (cmd.arm_fallback || cmd.arm_div) begin
        thresh    <= cmd.arm_div ? quot[23:0] : FALLBACK_THR;
        is_armed  <= 1'b1;
        last_beat <= now_r;
        warm_sum  <= '0;
        warm_cnt  <= '0;
      end
      if (cmd.fold_thr) begin
        thresh <= thr_sum[23:0];
      end
      if (cmd.edge_eval) begin
        if (sts.rise) begin
          above <= 1'b1;
          edg   <= 1'b1;
          if (ge_max) begin
            last_beat <= now_r;
          end
        end else if (fall) begin
          above <= 1'b0;
        end
      end
      if (cmd.rate_set || cmd.fold_rate) begin
        rate      <= cmd.fold_rate ? rate_sum[15:0] : rate_inst;
        upd       <= 1'b1;
        last_beat <= now_r;
      end
      if (cmd.tmo_eval && tmo_hit) begin
        rate     <= '0;
        is_armed <= 1'b0;
        warm_cnt <= '0;
        warm_sum <= '0;
        above    <= 1'b0;
        tmo      <= 1'b1;
      end
    end
  end

endmodule

[design/pbrd_ctrl.sv]
module pbrd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  pbrd_pkg::sts_t  sts,
  output pbrd_pkg::cmd_t  cmd
);
  import pbrd_pkg::*;

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_DECIDE    = 4'd1;
  localparam logic [3:0] ST_WARM_CHK  = 4'd2;
  localparam logic [3:0] ST_WARM_DIV  = 4'd3;
  localparam logic [3:0] ST_THR_FOLD  = 4'd4;
  localparam logic [3:0] ST_EDGE      = 4'd5;
  localparam logic [3:0] ST_RATE_DIV  = 4'd6;
  localparam logic [3:0] ST_RATE_CHK  = 4'd7;
  localparam logic [3:0] ST_RATE_FOLD = 4'd8;
  localparam logic [3:0] ST_TMO       = 4'd9;
  localparam logic [3:0] ST_DONE      = 4'd10;

  logic [3:0] state, state_next;
  logic       out_free;

  assign in_ready = state == ST_IDLE;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.armed) begin
          cmd.mul_thr = 1'b1;
          state_next  = ST_THR_FOLD;
        end else if (sts.x_ge_arm) begin
          cmd.warm_acc = 1'b1;
          state_next   = ST_WARM_CHK;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_WARM_CHK: begin
        if (!sts.warm_done) begin
          state_next = ST_DONE;
        end else if (sts.sum_zero) begin
          cmd.arm_fallback = 1'b1;
          state_next       = ST_DONE;
        end else begin
          cmd.div_warm = 1'b1;
          state_next   = ST_WARM_DIV;
        end
      end
      ST_WARM_DIV: begin
        if (sts.div_done) begin
          cmd.arm_div = 1'b1;
          state_next  = ST_DONE;
        end
      end
      ST_THR_FOLD: begin
        cmd.fold_thr = 1'b1;
        state_next   = ST_EDGE;
      end
      ST_EDGE: begin
        cmd.edge_eval = 1'b1;
        if (sts.rise && sts.in_win) begin
          cmd.div_rate = 1'b1;
          state_next   = ST_RATE_DIV;
        end else begin
          state_next = ST_TMO;
        end
      end
      ST_RATE_DIV: begin
        if (sts.div_done) begin
          cmd.rate_sat = 1'b1;
          state_next   = ST_RATE_CHK;
        end
      end
      ST_RATE_CHK: begin
        if (sts.rate_zero) begin
          cmd.rate_set = 1'b1;
          state_next   = ST_TMO;
        end else begin
          cmd.mul_rate = 1'b1;
          state_next   = ST_RATE_FOLD;
        end
      end
      ST_RATE_FOLD: begin
        cmd.fold_rate = 1'b1;
        state_next    = ST_TMO;
      end
      ST_TMO: begin
        cmd.tmo_eval = 1'b1;
        state_next   = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[design/pulse_beat_rate_detector_unit.sv]
// channel  dir  handshake                     payload
// s_*      in   s_tvalid / s_tready            s_tdata: ir_sample, time_ms, restart
// m_*      out  m_tvalid / m_tready            m_tdata: beat_rate, rate_updated,
//                                              beat_edge, armed, timed_out
// apb      in   psel & penable & pwrite        six 16-bit registers at 4*i
//
// One item at a time. Arming from a nonzero warm-up sum and an accepted beat
// go through the 28-step serial divider; other samples do not use it.
// s_tready returns in the cycle after the result is loaded.
// Synchronous active-high reset restores register defaults and clears state.
// A result waits in the output register while the next item is taken; the
// controller only stalls at its last step if that register is still full.
module pulse_beat_rate_detector_unit #(
  parameter int WARMUP_SAMPLES = pbrd_pkg::WARMUP_SAMPLES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [15:0] ir_sample, [47:16] time_ms, [48] restart, [55:49] zero
  input  logic [55:0]                   s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [15:0] beat_rate, [16] rate_updated, [17] beat_edge, [18] armed,
  // [19] timed_out, [23:20] zero
  output logic [23:0]                   m_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pbrd_pkg::ADDR_W-1:0]   paddr,
  input  logic [pbrd_pkg::PDATA_W-1:0]  pwdata,
  output logic [pbrd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import pbrd_pkg::*;

  cfg_t        cfg;
  cmd_t        cmd;
  sts_t        sts;
  logic [15:0] beat_rate;
  logic        rate_updated, beat_edge, armed, timed_out;

  pbrd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pbrd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pbrd_dp #(
    .WARMUP_SAMPLES (WARMUP_SAMPLES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .sts          (sts),
    .ir_sample    (s_tdata[15:0]),
    .time_ms      (s_tdata[47:16]),
    .restart      (s_tdata[48]),
    .beat_rate    (beat_rate),
    .rate_updated (rate_updated),
    .beat_edge    (beat_edge),
    .armed        (armed),
    .timed_out    (timed_out)
  );

  assign m_tdata = {4'h0, timed_out, armed, beat_edge, rate_updated, beat_rate};

endmodule
